// ----- src/pjht_pkg.sv -----
// Package for the peer join handshake table: sizes, opcodes, event kinds,
// handshake phases and reject reasons. No dependencies.
`timescale 1ns / 1ps
package pjht_pkg;
  localparam int PEERS        = 16;
  localparam int IDX_W        = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int CNT_W        = $clog2(PEERS + 1);
  localparam int TICK_REPORTS = 16;
  localparam int REP_W        = 5;

  localparam logic [2:0] OP_CONNECT = 3'd0;
  localparam logic [2:0] OP_DISCON  = 3'd1;
  localparam logic [2:0] OP_HELLO   = 3'd2;
  localparam logic [2:0] OP_JOIN    = 3'd3;
  localparam logic [2:0] OP_PING    = 3'd4;
  localparam logic [2:0] OP_OTHER   = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;
  localparam logic [2:0] OP_NONE    = 3'd7;

  localparam logic [3:0] EV_ACK       = 4'd0;
  localparam logic [3:0] EV_ACCEPT    = 4'd1;
  localparam logic [3:0] EV_REJECT    = 4'd2;
  localparam logic [3:0] EV_PONG      = 4'd3;
  localparam logic [3:0] EV_UNKNOWN   = 4'd4;
  localparam logic [3:0] EV_VIOLATION = 4'd5;
  localparam logic [3:0] EV_CONNECTED = 4'd6;
  localparam logic [3:0] EV_DISCONN   = 4'd7;
  localparam logic [3:0] EV_FULL      = 4'd8;
  localparam logic [3:0] EV_TICK      = 4'd9;

  localparam logic [2:0] PH_CONNECTED = 3'd1;
  localparam logic [2:0] PH_HELLO     = 3'd2;
  localparam logic [2:0] PH_JOIN_REQ  = 3'd3;
  localparam logic [2:0] PH_JOIN_ACC  = 3'd4;
  localparam logic [2:0] PH_SESSION   = 3'd5;
  localparam logic [2:0] PH_LEAVING   = 3'd6;

  localparam logic [2:0] RR_PROTOCOL = 3'd0;
  localparam logic [2:0] RR_CONTENT  = 3'd1;
  localparam logic [2:0] RR_FULL     = 3'd2;
  localparam logic [2:0] RR_INTERNAL = 3'd3;
  localparam logic [2:0] RR_TIMEOUT  = 3'd4;

  localparam logic [2:0] CFG_SESSION  = 3'd0;
  localparam logic [2:0] CFG_PROTOCOL = 3'd1;
  localparam logic [2:0] CFG_HASH     = 3'd2;
  localparam logic [2:0] CFG_PLIMIT   = 3'd3;
  localparam logic [2:0] CFG_IDLIMIT  = 3'd4;
  localparam logic [2:0] CFG_HELLO_TO = 3'd5;
  localparam logic [2:0] CFG_JOIN_TO  = 3'd6;
  localparam logic [2:0] CFG_OTHER_TO = 3'd7;

  typedef struct packed {
    logic        fire;
    logic        last;
    logic [3:0]  kind;
    logic [31:0] client;
    logic [15:0] player;
    logic [2:0]  reason;
    logic [31:0] stamp;
    logic [31:0] session;
  } evt_t;
endpackage

// ----- src/peer_join_handshake_table_unit.sv -----
// Top level of the peer join handshake table: the peer table, the scan
// sequencer and the result register. Depends on pjht_pkg.
`timescale 1ns / 1ps
// The block keeps a table of up to PEERS clients in arrival order and runs
// the server side of the join handshake. One input beat is taken when the
// block is idle; one table entry is examined per cycle by a single compare
// unit that walks an index from the head of the table. A connect, a lookup
// or a tick latches the beat, then visits entries in order until it finds
// its answer or runs past the end of the table, and a tick carries on
// after each timeout that it reports. Each result waits in an output
// register until the sink takes it, and the scan resumes after that. Opcode
// seven is dropped without a result. A tick rejects at most sixteen
// timed-out peers; the rest wait for the next tick.
// Configuration writes are meant for idle periods only.
module peer_join_handshake_table_unit
  import pjht_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // client[31:0], client_protocol[47:32], client_content_hash[79:48],
  // now_ms[111:80]
  input  logic [111:0] in_tdata,
  // opcode[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // peer_client_id[31:0], assigned_player[47:32], reject_reason[50:48],
  // time_stamp[82:51], session_out[114:83], zero fill above
  output logic [119:0] out_tdata,
  // event_kind[3:0]
  output logic [3:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;

  // Configuration registers.
  logic [31:0] session_r, hash_exp_r, hello_to_r, join_to_r, other_to_r;
  logic [15:0] proto_exp_r, id_limit_r;
  logic [4:0]  plimit_r;

  // Latched input beat.
  logic [2:0]  op_r;
  logic [31:0] cid_r, hash_r, now_r;
  logic [15:0] proto_r;

  // Peer table.
  logic        ent_valid_r  [PEERS];
  logic [31:0] ent_client_r [PEERS];
  logic [2:0]  ent_phase_r  [PEERS];
  logic [31:0] ent_since_r  [PEERS];
  logic [15:0] ent_player_r [PEERS];

  logic [15:0]      next_player_r;
  logic [4:0]       players_r;
  logic [CNT_W-1:0] idx_r;
  logic [REP_W-1:0] reports_r;

  // Result register.
  logic         out_valid_r, out_last_r;
  logic [3:0]   out_kind_r;
  logic [31:0]  out_client_r, out_stamp_r, out_session_r;
  logic [15:0]  out_player_r;
  logic [2:0]   out_reason_r;

  logic [IDX_W-1:0] cur;
  logic             at_end, hit, cur_valid;
  logic [2:0]       cur_phase;
  logic [31:0]      elapsed, limit;
  logic             timed_out;
  evt_t             ev;
  logic             do_store, do_remove, do_timeout, do_hello, do_join_fail;
  logic             do_join_ok, do_dec;

  assign cur       = idx_r[IDX_W-1:0];
  assign at_end    = (idx_r == CNT_W'(PEERS));
  assign cur_valid = ent_valid_r[cur];
  assign cur_phase = ent_phase_r[cur];
  assign hit       = cur_valid && (ent_client_r[cur] == cid_r);
  assign elapsed   = now_r - ent_since_r[cur];

  always_comb begin
    case (cur_phase)
      PH_CONNECTED: limit = hello_to_r;
      PH_HELLO:     limit = join_to_r;
      default:      limit = other_to_r;
    endcase
  end

  assign timed_out = cur_valid && (cur_phase >= PH_CONNECTED) &&
                     (cur_phase <= PH_JOIN_ACC) && (elapsed > limit);

  // One step of the scan: decide whether this entry produces a result.
  always_comb begin
    ev           = '0;
    ev.client    = cid_r;
    ev.last      = 1'b1;
    do_store     = 1'b0;
    do_remove    = 1'b0;
    do_timeout   = 1'b0;
    do_hello     = 1'b0;
    do_join_fail = 1'b0;
    do_join_ok   = 1'b0;
    do_dec       = 1'b0;
    if (state_r == S_SCAN) begin
      if (op_r == OP_TICK) begin
        if (at_end || reports_r == REP_W'(TICK_REPORTS)) begin
          ev.fire   = 1'b1;
          ev.kind   = EV_TICK;
          ev.client = '0;
        end else if (timed_out) begin
          ev.fire    = 1'b1;
          ev.last    = 1'b0;
          ev.kind    = EV_REJECT;
          ev.client  = ent_client_r[cur];
          ev.reason  = RR_TIMEOUT;
          do_timeout = 1'b1;
        end
      end else if (op_r == OP_CONNECT) begin
        if (at_end) begin
          ev.fire = 1'b1;
          ev.kind = EV_FULL;
        end else if (!cur_valid) begin
          ev.fire  = 1'b1;
          ev.kind  = EV_CONNECTED;
          do_store = 1'b1;
        end
      end else if (at_end) begin
        ev.fire = 1'b1;
        ev.kind = EV_UNKNOWN;
      end else if (hit) begin
        ev.fire = 1'b1;
        unique case (op_r)
          OP_DISCON: begin
            ev.kind   = EV_DISCONN;
            do_remove = 1'b1;
            do_dec    = (cur_phase == PH_SESSION || cur_phase == PH_JOIN_ACC) &&
                        (players_r != '0);
          end
          OP_HELLO: begin
            if (cur_phase != PH_CONNECTED) begin
              ev.kind = EV_VIOLATION;
            end else if (proto_r != proto_exp_r) begin
              ev.kind   = EV_REJECT;
              ev.reason = RR_PROTOCOL;
            end else if (hash_r != hash_exp_r) begin
              ev.kind   = EV_REJECT;
              ev.reason = RR_CONTENT;
            end else if (players_r >= plimit_r) begin
              ev.kind   = EV_REJECT;
              ev.reason = RR_FULL;
            end else begin
              ev.kind    = EV_ACK;
              ev.session = session_r;
              do_hello   = 1'b1;
            end
          end
          OP_JOIN: begin
            if (cur_phase != PH_HELLO) begin
              ev.kind = EV_VIOLATION;
            end else if (next_player_r >= id_limit_r) begin
              ev.kind      = EV_REJECT;
              ev.reason    = RR_INTERNAL;
              do_join_fail = 1'b1;
            end else begin
              ev.kind    = EV_ACCEPT;
              ev.player  = next_player_r;
              ev.session = session_r;
              do_join_ok = 1'b1;
            end
          end
          OP_PING: begin
            ev.kind  = EV_PONG;
            ev.stamp = now_r;
          end
          default: ev.kind = EV_VIOLATION;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      next_player_r <= 16'd1;
      players_r     <= '0;
      idx_r         <= '0;
      reports_r     <= '0;
      session_r     <= '0;
      proto_exp_r   <= 16'd1;
      hash_exp_r    <= '0;
      plimit_r      <= 5'd4;
      id_limit_r    <= 16'd65535;
      hello_to_r    <= 32'd10000;
      join_to_r     <= 32'd10000;
      other_to_r    <= 32'd30000;
      for (int i = 0; i < PEERS; i++) begin
        ent_valid_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SESSION:  session_r   <= cfg_wdata;
          CFG_PROTOCOL: proto_exp_r <= cfg_wdata[15:0];
          CFG_HASH:     hash_exp_r  <= cfg_wdata;
          CFG_PLIMIT:   plimit_r    <= cfg_wdata[4:0];
          CFG_IDLIMIT:  id_limit_r  <= cfg_wdata[15:0];
          CFG_HELLO_TO: hello_to_r  <= cfg_wdata;
          CFG_JOIN_TO:  join_to_r   <= cfg_wdata;
          CFG_OTHER_TO: other_to_r  <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r      <= in_tuser;
            cid_r     <= in_tdata[31:0];
            proto_r   <= in_tdata[47:32];
            hash_r    <= in_tdata[79:48];
            now_r     <= in_tdata[111:80];
            idx_r     <= '0;
            reports_r <= '0;
            if (in_tuser != OP_NONE) begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ev.fire) begin
            out_valid_r   <= 1'b1;
            out_last_r    <= ev.last;
            out_kind_r    <= ev.kind;
            out_client_r  <= ev.client;
            out_player_r  <= ev.player;
            out_reason_r  <= ev.reason;
            out_stamp_r   <= ev.stamp;
            out_session_r <= ev.session;
            state_r       <= S_OUT;
          end
          if (!ev.fire || !ev.last) begin
            idx_r <= idx_r + CNT_W'(1);
          end
          if (do_timeout) begin
            ent_phase_r[cur] <= PH_LEAVING;
            reports_r        <= reports_r + REP_W'(1);
          end
          if (do_store) begin
            ent_valid_r[cur]  <= 1'b1;
            ent_client_r[cur] <= cid_r;
            ent_phase_r[cur]  <= PH_CONNECTED;
            ent_since_r[cur]  <= now_r;
            ent_player_r[cur] <= '0;
          end
          if (do_hello) begin
            ent_phase_r[cur] <= PH_HELLO;
            ent_since_r[cur] <= now_r;
          end
          if (do_join_fail) begin
            ent_phase_r[cur] <= PH_JOIN_REQ;
            ent_since_r[cur] <= now_r;
          end
          if (do_join_ok) begin
            ent_phase_r[cur]  <= PH_SESSION;
            ent_since_r[cur]  <= now_r;
            ent_player_r[cur] <= next_player_r;
            next_player_r     <= next_player_r + 16'd1;
            if (players_r < 5'd31) begin
              players_r <= players_r + 5'd1;
            end
          end
          if (do_dec) begin
            players_r <= players_r - 5'd1;
          end
          if (do_remove) begin
            // Close the gap: every entry at or after the hit takes its successor.
            for (int i = 0; i < PEERS - 1; i++) begin
              if (IDX_W'(i) >= cur) begin
                ent_valid_r[i]  <= ent_valid_r[i+1];
                ent_client_r[i] <= ent_client_r[i+1];
                ent_phase_r[i]  <= ent_phase_r[i+1];
                ent_since_r[i]  <= ent_since_r[i+1];
                ent_player_r[i] <= ent_player_r[i+1];
              end
            end
            ent_valid_r[PEERS-1] <= 1'b0;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            state_r     <= out_last_r ? S_IDLE : S_SCAN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {5'd0, out_session_r, out_stamp_r, out_reason_r,
                       out_player_r, out_client_r};

  // A result is only presented while the sequencer waits on the sink.
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_OUT))
    else $error("result valid outside output state");

  // The scan index never runs past one beyond the table.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= CNT_W'(PEERS))
    else $error("scan index out of range");

  // A tick never reports more timeouts than the per-tick cap.
  a_rep_cap: assert property (@(posedge clk) disable iff (!rst_n)
    reports_r <= REP_W'(TICK_REPORTS))
    else $error("too many timeout reports");

  // Accepting an item always leaves idle, except for the ignored opcode.
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser != OP_NONE) |=> (state_r == S_SCAN))
    else $error("accepted item did not start a scan");
endmodule
